// File: rtl/hsfc_pkg.sv
// shared types and constants for the heat stencil fit cost block
package hsfc_pkg;

  localparam int DATA_W             = 32;
  localparam int COST_W             = 64;
  localparam int ROW_POINTS_DEFAULT = 8;
  localparam int LAP_W              = DATA_W + 3;
  localparam int LAP_LO_W           = 17;
  localparam int FRAC_W             = 24;

  localparam logic [DATA_W-1:0] STEP_COEF_RESET = 32'd4194304;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              saturated;
  } cost_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// File: rtl/hsfc_row_mem.sv
// row memory: one write port, one registered read port, per-entry valid bits
module hsfc_row_mem import hsfc_pkg::*; #(
  parameter int ROW_POINTS = ROW_POINTS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rd_en,
  input  logic [$clog2(ROW_POINTS)-1:0]        rd_addr,
  output logic signed [DATA_W-1:0]             rd_data,
  input  logic                                 wr_en,
  input  logic [$clog2(ROW_POINTS)-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0]             wr_data
);

  logic signed [DATA_W-1:0] mem [ROW_POINTS];
  logic [ROW_POINTS-1:0]    vld;
  logic signed [DATA_W-1:0] q;
  logic                     q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld <= vld[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = q_vld ? q : '0;

endmodule

// File: rtl/hsfc_stencil.sv
// stencil pipeline: sliding window over the read stream, laplacian, scale, clamp
module hsfc_stencil import hsfc_pkg::*; #(
  parameter int ROW_POINTS = ROW_POINTS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [DATA_W-1:0]                    step_coefficient,
  input  logic                                 data_valid,
  input  logic [$clog2(ROW_POINTS)-1:0]        data_idx,
  input  logic signed [DATA_W-1:0]             data,
  output logic                                 wr_valid,
  output logic [$clog2(ROW_POINTS)-1:0]        wr_addr,
  output logic signed [DATA_W-1:0]             wr_data,
  output logic                                 busy
);

  localparam int AW     = $clog2(ROW_POINTS);
  localparam int HI_W   = LAP_W - LAP_LO_W;
  localparam int LO_P_W = DATA_W + LAP_LO_W;
  localparam int HI_P_W = DATA_W + 1 + HI_W;
  localparam int PROD_W = DATA_W + LAP_W;
  localparam int DEL_W  = PROD_W - FRAC_W;
  localparam int SUM_W  = DEL_W + 1;

  logic signed [DATA_W-1:0] p1, p2;

  logic                     s1_valid;
  logic signed [LAP_W-1:0]  s1_lap;
  logic signed [DATA_W-1:0] s1_old;
  logic [AW-1:0]            s1_idx;

  logic                     s2_valid;
  logic [LO_P_W-1:0]        s2_lo;
  logic signed [HI_P_W-1:0] s2_hi;
  logic signed [DATA_W-1:0] s2_old;
  logic [AW-1:0]            s2_idx;

  logic                     s3_valid;
  logic signed [DEL_W-1:0]  s3_delta;
  logic signed [DATA_W-1:0] s3_old;
  logic [AW-1:0]            s3_idx;

  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] clamped;
  logic                     fire;

  // window holds u[k-2], u[k-1]; data is u[k], producing point k-1
  assign fire = data_valid && (data_idx >= AW'(2));

  assign lap = LAP_W'(p2) - (LAP_W'(p1) <<< 1) + LAP_W'(data);

  assign prod = (PROD_W'(s2_hi) <<< LAP_LO_W) + $signed({{(PROD_W - LO_P_W){1'b0}}, s2_lo});

  assign sum = SUM_W'(s3_old) + SUM_W'(s3_delta);

  always_comb begin
    if (sum > SUM_W'(DATA_MAX)) begin
      clamped = DATA_MAX;
    end else if (sum < SUM_W'(DATA_MIN)) begin
      clamped = DATA_MIN;
    end else begin
      clamped = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid) begin
      p2 <= p1;
      p1 <= data;
    end
    if (fire) begin
      s1_lap <= lap;
      s1_old <= p1;
      s1_idx <= data_idx - AW'(1);
    end
    if (s1_valid) begin
      s2_lo  <= LO_P_W'(step_coefficient) * LO_P_W'(s1_lap[LAP_LO_W-1:0]);
      s2_hi  <= $signed({1'b0, step_coefficient}) * $signed(s1_lap[LAP_W-1:LAP_LO_W]);
      s2_old <= s1_old;
      s2_idx <= s1_idx;
    end
    if (s2_valid) begin
      // arithmetic shift gives floor toward minus infinity
      s3_delta <= prod[PROD_W-1:FRAC_W];
      s3_old   <= s2_old;
      s3_idx   <= s2_idx;
    end
    if (s3_valid) begin
      wr_data <= clamped;
      wr_addr <= s3_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      wr_valid <= s3_valid;
    end
  end

  assign busy = s1_valid || s2_valid || s3_valid || wr_valid;

endmodule

// File: rtl/hsfc_cost.sv
// cost unit: squared error against row point 1, saturating accumulation
module hsfc_cost import hsfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] u1,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     last,
  output unit_status_t             status,
  output cost_res_t                res
);

  localparam int ERR_W = DATA_W + 1;
  localparam int SQ_W  = 2 * ERR_W;

  logic                    s1_valid;
  logic [ERR_W-1:0]        s1_mag;
  logic                    s1_last;
  logic                    s2_valid;
  logic [COST_W-1:0]       s2_sq;
  logic                    s2_last;
  logic [COST_W-1:0]       acc;
  logic                    sat;
  logic                    done;

  logic signed [ERR_W-1:0] err;
  logic [SQ_W-1:0]         sq_full;
  logic [COST_W:0]         acc_sum;
  logic [COST_W-1:0]       acc_new;
  logic                    sat_new;

  assign err     = ERR_W'(sample) - ERR_W'(u1);
  assign sq_full = SQ_W'(s1_mag) * SQ_W'(s1_mag);
  assign acc_sum = {1'b0, acc} + {1'b0, s2_sq};

  always_comb begin
    if (acc_sum[COST_W]) begin
      acc_new = '1;
      sat_new = 1'b1;
    end else begin
      acc_new = acc_sum[COST_W-1:0];
      sat_new = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_mag  <= err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      s1_last <= last;
    end
    if (s1_valid) begin
      // error magnitude stays below 2^32, so the square fits
      s2_sq   <= sq_full[COST_W-1:0];
      s2_last <= s1_last;
    end
    if (s2_valid) begin
      res.cost      <= acc_new;
      res.saturated <= sat_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
      acc      <= '0;
      sat      <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      done     <= s2_valid;
      if (s2_valid) begin
        if (s2_last) begin
          acc <= '0;
          sat <= 1'b0;
        end else begin
          acc <= acc_new;
          sat <= sat_new;
        end
      end
    end
  end

  assign status.busy = s1_valid || s2_valid;
  assign status.done = done;

endmodule

// File: rtl/heat_stencil_fit_cost.sv
// top level: one-dimensional heat stencil scored against observations
//
// Input channel (in_valid / in_stall): one word per row load or observation.
// A load word (mode 0) writes one row point without stalling the input; a
// point_index beyond the row is dropped. An observation word (mode 1) adds
// the squared error against row point 1 to the running cost and advances the
// row one time step. The row sits in a memory and is swept once per step, one
// point per cycle through the read port, so an observation keeps the input
// stalled through ROW_POINTS reads, the registered read, four stencil stages
// up to the write port and a check that the pipeline is empty.
// Output channel (out_valid / out_stall): an observation word with last set
// yields one cost word once its time step has drained; the cost and flag then
// clear. The output register holds the word while stalled, and further work
// continues until another cost word is ready, which then waits.
// Configuration: cfg_write loads cfg_data into the diffusion ratio; write only
// while idle.
// Reset (rst, synchronous): row reads as zero, cost cleared, ratio 0.25.
module heat_stencil_fit_cost import hsfc_pkg::*; #(
  parameter int ROW_POINTS = ROW_POINTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic [2:0]               point_index,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [COST_W-1:0]        cost,
  output logic                     cost_saturated
);

  localparam int AW = $clog2(ROW_POINTS);
  localparam int IW = (AW + 1 > 3) ? AW + 1 : 3;

  state_t state, state_next;

  logic [DATA_W-1:0]        step_coefficient;
  logic signed [DATA_W-1:0] item_sample;
  logic                     item_last;
  logic [AW-1:0]            rd_cnt;
  logic                     rd_pending;
  logic [AW-1:0]            rd_idx;

  logic                     in_acc;
  logic [IW-1:0]            load_idx;
  logic                     load_ok;
  logic                     rd_en;
  logic signed [DATA_W-1:0] rd_data;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic                     st_wr_valid;
  logic [AW-1:0]            st_wr_addr;
  logic signed [DATA_W-1:0] st_wr_data;
  logic                     st_busy;

  logic                     cost_start;
  unit_status_t             cost_status;
  cost_res_t                cost_res;

  logic                     drained;
  logic                     out_free;
  logic                     out_load;

  assign in_acc   = in_valid && !in_stall;
  assign load_idx = IW'(point_index);
  assign load_ok  = load_idx < IW'(ROW_POINTS);

  assign wr_en   = st_wr_valid || (in_acc && (mode == MODE_LOAD) && load_ok);
  assign wr_addr = st_wr_valid ? st_wr_addr : load_idx[AW-1:0];
  assign wr_data = st_wr_valid ? st_wr_data : sample;

  assign cost_start = rd_pending && (rd_idx == AW'(1));
  assign drained    = !rd_pending && !st_busy && !cost_status.busy;
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (mode == MODE_STEP)) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (rd_cnt == AW'(ROW_POINTS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drained) begin
          if (!item_last || out_free) state_next = ST_IDLE;
          else                        state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_SWEEP: rd_en    = 1'b1;
      ST_DRAIN: out_load = drained && item_last && out_free;
      ST_HOLD:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step_coefficient <= STEP_COEF_RESET;
      rd_cnt           <= '0;
      rd_pending       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_en;
      if (cfg_write) begin
        step_coefficient <= cfg_data;
      end
      if (rd_en) begin
        rd_cnt <= rd_cnt + AW'(1);
      end else begin
        rd_cnt <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_cnt;
    if (in_acc) begin
      item_sample <= sample;
      item_last   <= last;
    end
    if (out_load) begin
      cost           <= cost_res.cost;
      cost_saturated <= cost_res.saturated;
    end
  end

  hsfc_row_mem #(
    .ROW_POINTS(ROW_POINTS)
  ) u_row_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  hsfc_stencil #(
    .ROW_POINTS(ROW_POINTS)
  ) u_stencil (
    .clk              (clk),
    .rst              (rst),
    .step_coefficient (step_coefficient),
    .data_valid       (rd_pending),
    .data_idx         (rd_idx),
    .data             (rd_data),
    .wr_valid         (st_wr_valid),
    .wr_addr          (st_wr_addr),
    .wr_data          (st_wr_data),
    .busy             (st_busy)
  );

  hsfc_cost u_cost (
    .clk    (clk),
    .rst    (rst),
    .start  (cost_start),
    .u1     (rd_data),
    .sample (item_sample),
    .last   (item_last),
    .status (cost_status),
    .res    (cost_res)
  );

  a_stencil_write_in_step: assert property (@(posedge clk) disable iff (rst)
    st_wr_valid |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("row write-back outside a time step");

  a_cost_done_in_step: assert property (@(posedge clk) disable iff (rst)
    cost_status.done |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("cost update finished outside a time step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("cost word overwritten while stalled");

  a_read_return_in_step: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("row read returned outside a time step");

endmodule
